>>> src/pwfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// pwfd_pkg: shared types, nominal pulse timings and phase codes for the
// pulse width frame decoder; no dependencies

package pwfd_pkg;

  // nominal durations in microseconds
  localparam int unsigned NOM_W = 14;
  localparam logic [NOM_W-1:0] SYNC_MARK = 14'd450;
  localparam logic [NOM_W-1:0] SYNC_GAP  = 14'd11880;
  localparam logic [NOM_W-1:0] ONE_MARK  = 14'd1240;
  localparam logic [NOM_W-1:0] ONE_GAP   = 14'd510;
  localparam logic [NOM_W-1:0] ZERO_MARK = 14'd470;
  localparam logic [NOM_W-1:0] ZERO_GAP  = 14'd1300;
  localparam logic [NOM_W-1:0] STOP_MARK = 14'd450;
  localparam logic [NOM_W-1:0] STOP_GAP  = 14'd450;

  localparam int unsigned TOL_W = 7;
  localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;
  localparam logic [TOL_W-1:0] TOL_MAX   = 7'd100;

  // bounds are nominal * (100 -/+ t), kept unscaled (max 11880 * 200)
  localparam int unsigned BOUND_W = 22;

  localparam int unsigned FRAME_BITS = 24;
  localparam int unsigned COUNT_W = 5;

  // receive phases
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_STOP1 = 2'd2;
  localparam logic [1:0] PH_STOP2 = 2'd3;

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } bound_t;

  typedef struct packed {
    bound_t sync_mark;
    bound_t sync_gap;
    bound_t one_mark;
    bound_t one_gap;
    bound_t zero_mark;
    bound_t zero_gap;
    bound_t stop_mark;
    bound_t stop_gap;
  } bound_set_t;

  // scaled window for one nominal at a clamped tolerance
  function automatic bound_t bound_of(input logic [NOM_W-1:0] nominal,
                                      input logic [TOL_W-1:0] pct);
    bound_t b;
    logic [7:0] lo_pct;
    logic [7:0] hi_pct;
    lo_pct = 8'd100 - {1'b0, pct};
    hi_pct = 8'd100 + {1'b0, pct};
    b.lo = BOUND_W'(nominal) * BOUND_W'(lo_pct);
    b.hi = BOUND_W'(nominal) * BOUND_W'(hi_pct);
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/pwfd_bounds.sv
`timescale 1ns / 1ps
`default_nettype none
// pwfd_bounds: tolerance register and registered match windows for every
// nominal pulse; depends on pwfd_pkg

module pwfd_bounds (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [pwfd_pkg::TOL_W-1:0] cfg_wdata,
  output pwfd_pkg::bound_set_t            bounds
);
  import pwfd_pkg::*;

  logic [TOL_W-1:0] tolerance;
  logic [TOL_W-1:0] tol_clamped;
  bound_set_t       bounds_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // anything above 100 percent behaves as 100
  assign tol_clamped = (tolerance > TOL_MAX) ? TOL_MAX : tolerance;

  always_comb begin
    bounds_next.sync_mark = bound_of(SYNC_MARK, tol_clamped);
    bounds_next.sync_gap  = bound_of(SYNC_GAP,  tol_clamped);
    bounds_next.one_mark  = bound_of(ONE_MARK,  tol_clamped);
    bounds_next.one_gap   = bound_of(ONE_GAP,   tol_clamped);
    bounds_next.zero_mark = bound_of(ZERO_MARK, tol_clamped);
    bounds_next.zero_gap  = bound_of(ZERO_GAP,  tol_clamped);
    bounds_next.stop_mark = bound_of(STOP_MARK, tol_clamped);
    bounds_next.stop_gap  = bound_of(STOP_GAP,  tol_clamped);
  end

  always_ff @(posedge clk) begin
    bounds <= bounds_next;
  end

endmodule

`default_nettype wire

>>> src/pwfd_match.sv
`timescale 1ns / 1ps
`default_nettype none
// pwfd_match: tests one mark/gap pair, scaled by 100, against one pair of
// windows; depends on pwfd_pkg

module pwfd_match #(
  parameter int SCALED_W = 23
) (
  input  wire logic [SCALED_W-1:0] mark_sc,
  input  wire logic [SCALED_W-1:0] gap_sc,
  input  wire pwfd_pkg::bound_t    mark_b,
  input  wire pwfd_pkg::bound_t    gap_b,
  output logic                     hit
);
  import pwfd_pkg::*;

  logic mark_ok;
  logic gap_ok;

  // m >= floor(lo/100) <=> 100m + 99 >= lo ; m <= floor(hi/100) <=> 100m <= hi
  assign mark_ok = (mark_sc + SCALED_W'(99) >= SCALED_W'(mark_b.lo)) &&
                   (mark_sc <= SCALED_W'(mark_b.hi));
  assign gap_ok  = (gap_sc + SCALED_W'(99) >= SCALED_W'(gap_b.lo)) &&
                   (gap_sc <= SCALED_W'(gap_b.hi));
  assign hit = mark_ok && gap_ok;

endmodule

`default_nettype wire

>>> src/pulse_width_frame_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// pulse_width_frame_decoder_core: on-off keyed frame decoder top level
// depends on pwfd_pkg, pwfd_bounds and pwfd_match
//
// usage
// - input channel (in_valid/in_ready) carries one word per measured pulse:
//   mark_us and gap_us in microseconds
// - output channel (out_valid/out_ready) carries one word per complete
//   frame: device_id, group_id and payload_bits
// - cfg_we/cfg_wdata writes the tolerance in percent (reset 25); write it
//   only while no word is in flight
// - a word is taken into the input register and decoded from there once the
//   output register is free or being emptied; a frame result lands in the
//   output register and raises out_valid after the closing stop word
// - throughput is one word per cycle while no held result blocks the decode
//   stage; the state step (compare, shift, phase update) is a single pass
//   of logic between the input register and the state and output registers
// - when the receiver stalls, the held result blocks the decode stage and
//   one more word waits in the input register before in_ready drops
// - synchronous reset clears the phase, frame bits and both valid flags
//   and sets the tolerance back to 25 percent

module pulse_width_frame_decoder_core #(
  parameter int DURATION_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [pwfd_pkg::TOL_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [15:0]                mark_us,
  input  wire logic [15:0]                gap_us,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [4:0]                      device_id,
  output logic [14:0]                     group_id,
  output logic [3:0]                      payload_bits
);
  import pwfd_pkg::*;

  // room for 100 * duration + 99 and for the widest bound
  localparam int ScaledW = (DURATION_WIDTH + 7 > BOUND_W) ? DURATION_WIDTH + 7
                                                          : BOUND_W;
  localparam int ExtW = DURATION_WIDTH + 16;

  // input register
  logic                      in_held;
  logic [DURATION_WIDTH-1:0] mark_d;
  logic [DURATION_WIDTH-1:0] gap_d;

  // frame state
  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [COUNT_W-1:0]    bit_count;
  logic [COUNT_W-1:0]    bit_count_next;
  logic [FRAME_BITS-1:0] shift_bits;
  logic [FRAME_BITS-1:0] shift_bits_next;
  logic                  emit;

  logic       advance;
  bound_set_t bounds;

  logic [ExtW-1:0]    mark_ext;
  logic [ExtW-1:0]    gap_ext;
  logic [ScaledW-1:0] mark_sc;
  logic [ScaledW-1:0] gap_sc;
  logic               sync_hit;
  logic               one_hit;
  logic               zero_hit;
  logic               stop_hit;
  logic               matched;
  logic [COUNT_W-1:0] count_inc;

  pwfd_bounds u_bounds (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bounds    (bounds)
  );

  // decode stage moves when the output register is free or being emptied
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  // keep only the low DURATION_WIDTH bits of each measured duration
  assign mark_ext = ExtW'(mark_us);
  assign gap_ext  = ExtW'(gap_us);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mark_d <= mark_ext[DURATION_WIDTH-1:0];
      gap_d  <= gap_ext[DURATION_WIDTH-1:0];
    end
  end

  // durations times 100 as shift-add (64 + 32 + 4)
  assign mark_sc = (ScaledW'(mark_d) << 6) + (ScaledW'(mark_d) << 5) +
                   (ScaledW'(mark_d) << 2);
  assign gap_sc  = (ScaledW'(gap_d) << 6) + (ScaledW'(gap_d) << 5) +
                   (ScaledW'(gap_d) << 2);

  pwfd_match #(.SCALED_W(ScaledW)) u_sync (
    .mark_sc (mark_sc),
    .gap_sc  (gap_sc),
    .mark_b  (bounds.sync_mark),
    .gap_b   (bounds.sync_gap),
    .hit     (sync_hit)
  );

  pwfd_match #(.SCALED_W(ScaledW)) u_one (
    .mark_sc (mark_sc),
    .gap_sc  (gap_sc),
    .mark_b  (bounds.one_mark),
    .gap_b   (bounds.one_gap),
    .hit     (one_hit)
  );

  pwfd_match #(.SCALED_W(ScaledW)) u_zero (
    .mark_sc (mark_sc),
    .gap_sc  (gap_sc),
    .mark_b  (bounds.zero_mark),
    .gap_b   (bounds.zero_gap),
    .hit     (zero_hit)
  );

  pwfd_match #(.SCALED_W(ScaledW)) u_stop (
    .mark_sc (mark_sc),
    .gap_sc  (gap_sc),
    .mark_b  (bounds.stop_mark),
    .gap_b   (bounds.stop_gap),
    .hit     (stop_hit)
  );

  assign count_inc = bit_count + COUNT_W'(1);

  // one state step per word
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_bits_next = shift_bits;
    matched         = 1'b0;
    emit            = 1'b0;
    case (phase)
      PH_DATA: begin
        // a word that fits both a one and a zero counts as a one
        if (one_hit || zero_hit) begin
          matched         = 1'b1;
          shift_bits_next = {shift_bits[FRAME_BITS-2:0], one_hit};
          bit_count_next  = count_inc;
          if (count_inc >= COUNT_W'(FRAME_BITS)) begin
            phase_next = PH_STOP1;
          end
        end
      end
      PH_STOP1: begin
        if (stop_hit) begin
          matched    = 1'b1;
          phase_next = PH_STOP2;
        end
      end
      PH_STOP2: begin
        if (stop_hit) begin
          matched         = 1'b1;
          emit            = 1'b1;
          phase_next      = PH_HUNT;
          bit_count_next  = '0;
          shift_bits_next = '0;
        end
      end
      default: begin
      end
    endcase
    // mismatch drops back to hunting, and the same word may start a frame
    if (!matched) begin
      phase_next      = sync_hit ? PH_DATA : PH_HUNT;
      bit_count_next  = '0;
      shift_bits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bit_count  <= '0;
      shift_bits <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_bits <= shift_bits_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      device_id    <= shift_bits[23:19];
      group_id     <= shift_bits[18:4];
      payload_bits <= shift_bits[3:0];
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/pulse_width_frame_decoder_core_tb.sv
`timescale 1ns / 1ps
// pulse_width_frame_decoder_core_tb: self-checking bench for the pulse width frame decoder
// drives mark/gap words, predicts decoded frames and checks every result field
// depends on pwfd_pkg and pulse_width_frame_decoder_core

module pulse_width_frame_decoder_core_tb;
  import pwfd_pkg::*;

  localparam int unsigned DURATION_WIDTH = 16;
  localparam int unsigned DUR_MASK = (1 << DURATION_WIDTH) - 1;
  // input register plus decode stage, with margin
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_BUDGET = 215;

  typedef struct packed {
    logic [4:0]  device;
    logic [14:0] group;
    logic [3:0]  payload;
  } frame_t;

  typedef enum {ROW_PAIR, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] mark;
    logic [15:0] gap;
    logic [23:0] word;
    bit          typed;
    frame_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] mark_us = '0;
  logic [15:0] gap_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  device_id;
  logic [14:0] group_id;
  logic [3:0]  payload_bits;

  // predictor state, mirrors the decoder's phase, bit count and shift register
  logic [6:0]  tol_setting = TOL_RESET;
  logic [1:0]  rx_phase = PH_HUNT;
  logic [4:0]  rx_count = '0;
  logic [23:0] rx_bits = '0;

  frame_t frames_due[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  frames_checked = 0;
  int  settings_used = 1;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  hold_off_req = 1'b0;

  // directed words: extremes of the duration fields, a sync while hunting,
  // then a frame whose own sync lands in the data phase (mismatch, re-sync)
  // with every duration sitting on a window bound
  stim_row_t directed_rows [4] = '{
    '{ROW_PAIR,  16'd0,    16'd0,     24'd0,       1'b0, '0},
    '{ROW_PAIR,  16'hFFFF, 16'hFFFF,  24'd0,       1'b0, '0},
    '{ROW_PAIR,  16'd450,  16'd11880, 24'd0,       1'b0, '0},
    '{ROW_FRAME, 16'd0,    16'd0,     24'hA5C3E1,  1'b1, '{5'h14, 15'h5C3E, 4'h1}}
  };

  pulse_width_frame_decoder_core #(
    .DURATION_WIDTH(DURATION_WIDTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mark_us     (mark_us),
    .gap_us      (gap_us),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .device_id   (device_id),
    .group_id    (group_id),
    .payload_bits(payload_bits)
  );

  always #5 clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #(10_000_000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------
  // window math: bounds are rounded down, tolerance above 100 clamps to 100
  // ---------------------------------------------------------------------
  function automatic int unsigned clamped_tol();
    return (tol_setting > 7'd100) ? 100 : int'(tol_setting);
  endfunction

  function automatic int unsigned window_lo(input int unsigned nominal);
    return nominal * (100 - clamped_tol()) / 100;
  endfunction

  function automatic int unsigned window_hi(input int unsigned nominal);
    return nominal * (100 + clamped_tol()) / 100;
  endfunction

  function automatic bit pair_fits(input int unsigned m, input int unsigned g,
                                   input int unsigned nm, input int unsigned ng);
    return m >= window_lo(nm) && m <= window_hi(nm) &&
           g >= window_lo(ng) && g <= window_hi(ng);
  endfunction

  // one step of the frame decoder for an accepted word
  task automatic decode_step(input logic [15:0] m_in, input logic [15:0] g_in,
                             output bit got, output frame_t res);
    int unsigned m;
    int unsigned g;
    bit hit;
    m = m_in & DUR_MASK;
    g = g_in & DUR_MASK;
    hit = 1'b0;
    got = 1'b0;
    res = '0;
    case (rx_phase)
      PH_DATA: begin
        // a pair inside both windows counts as a one
        if (pair_fits(m, g, ONE_MARK, ONE_GAP)) begin
          rx_bits = {rx_bits[22:0], 1'b1};
          hit = 1'b1;
        end else if (pair_fits(m, g, ZERO_MARK, ZERO_GAP)) begin
          rx_bits = {rx_bits[22:0], 1'b0};
          hit = 1'b1;
        end
        if (hit) begin
          rx_count = rx_count + 5'd1;
          if (rx_count >= FRAME_BITS) rx_phase = PH_STOP1;
        end
      end
      PH_STOP1: begin
        if (pair_fits(m, g, STOP_MARK, STOP_GAP)) begin
          rx_phase = PH_STOP2;
          hit = 1'b1;
        end
      end
      PH_STOP2: begin
        if (pair_fits(m, g, STOP_MARK, STOP_GAP)) begin
          res = '{rx_bits[23:19], rx_bits[18:4], rx_bits[3:0]};
          got = 1'b1;
          rx_phase = PH_HUNT;
          rx_count = '0;
          rx_bits = '0;
          hit = 1'b1;
        end
      end
      default: ;
    endcase
    // any miss drops back to hunting and the same pair is tried as a sync
    if (!hit) begin
      rx_phase = PH_HUNT;
      rx_count = '0;
      rx_bits = '0;
      if (pair_fits(m, g, SYNC_MARK, SYNC_GAP)) rx_phase = PH_DATA;
    end
  endtask

  // gap lengths: mostly short ones, and in one draw of twenty a long one
  function automatic int idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  // duration inside the window, biased toward the bounds
  function automatic logic [15:0] near(input int unsigned nominal);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'(window_lo(nominal));
    if (r < 4) return 16'(window_hi(nominal));
    return 16'($urandom_range(window_lo(nominal), window_hi(nominal)));
  endfunction

  // duration just past a bound; at full tolerance only the upper side exists
  function automatic logic [15:0] off_window(input int unsigned nominal);
    if (window_lo(nominal) > 0 && $urandom_range(0, 1) == 1)
      return 16'(window_lo(nominal) - 1);
    return 16'(window_hi(nominal) + 1);
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  // offers one word, waits for acceptance, then predicts what it causes;
  // called and returning on a rising edge
  task automatic send_word(input logic [15:0] m, input logic [15:0] g,
                           input bit use_typed, input frame_t typed);
    bit got;
    frame_t res;
    mark_us <= m;
    gap_us <= g;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    decode_step(m, g, got, res);
    if (got) frames_due.push_back(use_typed ? typed : res);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // one nominal pair: on the bounds (directed), in range, or broken
  task automatic send_pair(input int unsigned nm, input int unsigned ng,
                           input bit edge_walk, input bit flip, input int corrupt_pm,
                           input bit use_typed, input frame_t typed);
    logic [15:0] m;
    logic [15:0] g;
    if (edge_walk) begin
      m = 16'(flip ? window_hi(nm) : window_lo(nm));
      g = 16'(flip ? window_lo(ng) : window_hi(ng));
    end else if ($urandom_range(0, 999) < corrupt_pm) begin
      case ($urandom_range(0, 2))
        0: begin
          m = off_window(nm);
          g = near(ng);
        end
        1: begin
          m = near(nm);
          g = off_window(ng);
        end
        default: begin
          m = 16'($urandom_range(0, 65535));
          g = 16'($urandom_range(0, 65535));
        end
      endcase
    end else begin
      m = near(nm);
      g = near(ng);
    end
    send_word(m, g, use_typed, typed);
  endtask

  // sync, nbits data bits msb first, and optionally the two stop pairs
  task automatic send_frame(input logic [23:0] word, input int nbits, input bit with_stops,
                            input int corrupt_pm, input bit edge_walk,
                            input bit use_typed, input frame_t typed);
    bit b;
    send_pair(SYNC_MARK, SYNC_GAP, edge_walk, 1'b1, corrupt_pm, 1'b0, '0);
    for (int i = 0; i < nbits; i++) begin
      b = word[23 - i];
      send_pair(b ? ONE_MARK : ZERO_MARK, b ? ONE_GAP : ZERO_GAP, edge_walk, i[0],
                corrupt_pm, 1'b0, '0);
    end
    if (with_stops) begin
      send_pair(STOP_MARK, STOP_GAP, edge_walk, 1'b0, corrupt_pm, 1'b0, '0);
      send_pair(STOP_MARK, STOP_GAP, edge_walk, 1'b1, corrupt_pm, use_typed, typed);
    end
  endtask

  function automatic logic [23:0] random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'h000000;
    if (r < 10) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  // mostly whole frames with random content, some cut short, some noise;
  // noise words that the hunter just drops are not counted
  task automatic random_traffic(input int budget);
    int sent;
    int r;
    int nb;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_frame(random_word(), 24, 1'b1, 8, 1'b0, 1'b0, '0);
        sent += 27;
      end else if (r < 87) begin
        nb = $urandom_range(0, 23);
        send_frame(random_word(), nb, 1'b0, 30, 1'b0, 1'b0, '0);
        sent += nb + 1;
      end else if (r < 94) begin
        send_word(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'b0, '0);
      end else begin
        // near miss of a sync, then a stop pair while hunting
        send_pair(SYNC_MARK, SYNC_GAP, 1'b0, 1'b0, 1000, 1'b0, '0);
        send_pair(STOP_MARK, STOP_GAP, 1'b0, 1'b0, 0, 1'b0, '0);
      end
    end
  endtask

  // register writes happen only once the decoder has gone quiet
  task automatic write_tolerance(input logic [6:0] pct);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wdata <= pct;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_setting = pct;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // receiver side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (receiver_idles && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // each accepted result against the oldest predicted frame
  always @(posedge clk) begin : result_check
    frame_t want;
    if (!rst && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame device_id %0h group_id %0h payload_bits %0h",
                 $time, device_id, group_id, payload_bits);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        frames_checked++;
        if (device_id !== want.device) begin
          $display("%0t: device_id expected %0h got %0h", $time, want.device, device_id);
          mismatches++;
        end
        if (group_id !== want.group) begin
          $display("%0t: group_id expected %0h got %0h", $time, want.group, group_id);
          mismatches++;
        end
        if (payload_bits !== want.payload) begin
          $display("%0t: payload_bits expected %0h got %0h", $time, want.payload,
                   payload_bits);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0] plan [6];
    plan = '{7'd0, 7'd100, 7'd127, 7'd10, 7'd60, 7'd25};
    plan[3] = 7'($urandom_range(1, 99));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset tolerance
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_PAIR)
        send_word(directed_rows[i].mark, directed_rows[i].gap, 1'b0, '0);
      else
        send_frame(directed_rows[i].word, 24, 1'b1, 0, 1'b1,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // receiver holds off for a long stretch while clean frames keep coming,
    // so the output and input registers fill and in_ready drops
    sender_idles = 1'b0;
    hold_off_req = 1'b1;
    repeat (4) send_frame(random_word(), 24, 1'b1, 0, 1'b0, 1'b0, '0);
    sender_idles = 1'b1;
    random_traffic(PHASE_BUDGET);

    // tolerance sweep; the 100 percent phase runs with no idling at all
    foreach (plan[p]) begin
      write_tolerance(plan[p]);
      sender_idles = (p != 1);
      receiver_idles = (p != 1);
      random_traffic(PHASE_BUDGET);
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;

    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 4) @(posedge clk);

    $display("run covered %0d words and %0d decoded frames across %0d tolerance settings",
             words_sent, frames_checked, settings_used);
    $display("including window bounds, clamped tolerance, re-sync and a long output stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
